// ===== sv/dcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// dcpu_pkg
// Shared kinds, result and pipeline item types for the DCPU-16 basic ALU.
// ----------------------------------------------------------------------------
package dcpu_pkg;

	localparam int WordW      = 16;
	localparam int DivStages  = 16;
	// Index of the divider stage that completes the sixteenth quotient step.
	localparam int DivRemStage = 7;

	localparam logic [4:0] K_SET = 5'd0;
	localparam logic [4:0] K_ADD = 5'd1;
	localparam logic [4:0] K_SUB = 5'd2;
	localparam logic [4:0] K_MUL = 5'd3;
	localparam logic [4:0] K_MLI = 5'd4;
	localparam logic [4:0] K_DIV = 5'd5;
	localparam logic [4:0] K_DVI = 5'd6;
	localparam logic [4:0] K_MOD = 5'd7;
	localparam logic [4:0] K_MDI = 5'd8;
	localparam logic [4:0] K_AND = 5'd9;
	localparam logic [4:0] K_BOR = 5'd10;
	localparam logic [4:0] K_XOR = 5'd11;
	localparam logic [4:0] K_SHR = 5'd12;
	localparam logic [4:0] K_ASR = 5'd13;
	localparam logic [4:0] K_SHL = 5'd14;
	localparam logic [4:0] K_IFB = 5'd15;
	localparam logic [4:0] K_IFC = 5'd16;
	localparam logic [4:0] K_IFE = 5'd17;
	localparam logic [4:0] K_IFN = 5'd18;
	localparam logic [4:0] K_IFG = 5'd19;
	localparam logic [4:0] K_IFA = 5'd20;
	localparam logic [4:0] K_IFL = 5'd21;
	localparam logic [4:0] K_IFU = 5'd22;
	localparam logic [4:0] K_ADX = 5'd23;
	localparam logic [4:0] K_SBX = 5'd24;
	localparam logic [4:0] K_STI = 5'd25;
	localparam logic [4:0] K_STD = 5'd26;

	localparam logic [1:0] STEP_NONE = 2'b00;
	localparam logic [1:0] STEP_INC  = 2'b01;
	localparam logic [1:0] STEP_DEC  = 2'b11;

	typedef struct packed {
		logic [WordW-1:0] b_result;
		logic             b_write;
		logic [WordW-1:0] ex_result;
		logic             ex_write;
		logic             skip_next;
		logic [1:0]       index_step;
	} res_t;

	typedef struct packed {
		logic [4:0]         kind;
		logic [WordW-1:0]   b;
		logic [WordW-1:0]   ex;
		res_t               res;
		logic [2*WordW-1:0] prod;
		logic               neg_q;
		logic               neg_r;
		logic               dzero;
		logic [WordW-1:0]   r;
		logic [2*WordW-1:0] x;
		logic [WordW-1:0]   d;
		logic [WordW-1:0]   rem;
	} pipe_t;

endpackage

// ===== sv/dcpu_front.sv =====
// ----------------------------------------------------------------------------
// dcpu_front
// First stage: multiplier, adders, logic, shifts, tests and divider operand setup.
// ----------------------------------------------------------------------------
module dcpu_front import dcpu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [4:0]       kind,
	input  logic [WordW-1:0] b_value,
	input  logic [WordW-1:0] a_value,
	input  logic [WordW-1:0] ex_in,
	output logic             out_valid,
	output pipe_t            out_data,
	input  logic             out_ready
);

	logic                 valid_s1;
	pipe_t                data_s1;
	pipe_t                nxt;
	res_t                 res;
	logic                 sgn_mul;
	logic                 sgn_div;
	logic signed [WordW:0]     mb;
	logic signed [WordW:0]     ma;
	logic signed [2*WordW+1:0] prod_full;
	logic [WordW:0]       sum;
	logic [WordW+1:0]     sum_x;
	logic signed [WordW+2:0] dif_x;
	logic [WordW-1:0]     dif;
	logic [2*WordW-1:0]   shr_v;
	logic [2*WordW-1:0]   shl_v;
	logic signed [2*WordW-1:0] asr_v;
	logic                 big_shift;

	assign in_ready = !valid_s1 || out_ready;

	// Multiplier operands are sign extended to 17 bits for MLI only.
	assign sgn_mul   = (kind == K_MLI);
	assign mb        = {sgn_mul & b_value[WordW-1], b_value};
	assign ma        = {sgn_mul & a_value[WordW-1], a_value};
	assign prod_full = mb * ma;

	// Adders and shifters.
	assign sum   = {1'b0, b_value} + {1'b0, a_value};
	assign sum_x = {2'b0, b_value} + {2'b0, a_value} + {2'b0, ex_in};
	assign dif_x = $signed({3'b0, b_value}) - $signed({3'b0, a_value})
		+ $signed({3'b0, ex_in});
	assign dif   = b_value - a_value;
	assign big_shift = (a_value[WordW-1:5] != '0);
	assign shr_v = {b_value, {WordW{1'b0}}} >> a_value[4:0];
	assign shl_v = {{WordW{1'b0}}, b_value} << a_value[4:0];
	assign asr_v = $signed({b_value, {WordW{1'b0}}}) >>> a_value[4:0];

	// Results of the single-stage kinds.
	always_comb begin
		res            = '0;
		res.b_result   = b_value;
		res.b_write    = 1'b1;
		res.ex_result  = ex_in;
		res.index_step = STEP_NONE;
		unique case (kind)
			K_SET: res.b_result = a_value;
			K_ADD: begin
				res.b_result  = sum[WordW-1:0];
				res.ex_result = {{(WordW-1){1'b0}}, sum[WordW]};
				res.ex_write  = 1'b1;
			end
			K_SUB: begin
				res.b_result  = dif;
				res.ex_result = {WordW{b_value < a_value}};
				res.ex_write  = 1'b1;
			end
			K_MUL, K_MLI, K_DIV, K_DVI: res.ex_write = 1'b1;
			K_MOD, K_MDI: ;
			K_AND: res.b_result = b_value & a_value;
			K_BOR: res.b_result = b_value | a_value;
			K_XOR: res.b_result = b_value ^ a_value;
			K_SHR: begin
				res.ex_write  = 1'b1;
				res.b_result  = big_shift ? '0 : shr_v[2*WordW-1:WordW];
				res.ex_result = big_shift ? '0 : shr_v[WordW-1:0];
			end
			K_ASR: begin
				res.ex_write  = 1'b1;
				res.b_result  = big_shift ? {WordW{b_value[WordW-1]}}
					: asr_v[2*WordW-1:WordW];
				res.ex_result = big_shift ? {WordW{b_value[WordW-1]}}
					: asr_v[WordW-1:0];
			end
			K_SHL: begin
				res.ex_write  = 1'b1;
				res.b_result  = big_shift ? '0 : shl_v[WordW-1:0];
				res.ex_result = big_shift ? '0 : shl_v[2*WordW-1:WordW];
			end
			K_IFB: begin res.b_write = 1'b0; res.skip_next = (b_value & a_value) == '0; end
			K_IFC: begin res.b_write = 1'b0; res.skip_next = (b_value & a_value) != '0; end
			K_IFE: begin res.b_write = 1'b0; res.skip_next = b_value != a_value; end
			K_IFN: begin res.b_write = 1'b0; res.skip_next = b_value == a_value; end
			K_IFG: begin res.b_write = 1'b0; res.skip_next = !(b_value > a_value); end
			K_IFA: begin
				res.b_write   = 1'b0;
				res.skip_next = !($signed(b_value) > $signed(a_value));
			end
			K_IFL: begin res.b_write = 1'b0; res.skip_next = !(b_value < a_value); end
			K_IFU: begin
				res.b_write   = 1'b0;
				res.skip_next = !($signed(b_value) < $signed(a_value));
			end
			K_ADX: begin
				res.b_result  = sum_x[WordW-1:0];
				res.ex_result = {{(WordW-1){1'b0}}, sum_x[WordW+1:WordW] != 2'b00};
				res.ex_write  = 1'b1;
			end
			K_SBX: begin
				res.b_result  = dif_x[WordW-1:0];
				res.ex_write  = 1'b1;
				if (dif_x < 0) begin
					res.ex_result = {WordW{1'b1}};
				end else if (dif_x[WordW+1:WordW] != 2'b00) begin
					res.ex_result = {{(WordW-1){1'b0}}, 1'b1};
				end else begin
					res.ex_result = '0;
				end
			end
			K_STI: begin res.b_result = a_value; res.index_step = STEP_INC; end
			K_STD: begin res.b_result = a_value; res.index_step = STEP_DEC; end
			default: res.b_write = 1'b0;
		endcase
	end

	// Divider operands are magnitudes; the signs are fixed at the back end.
	assign sgn_div = (kind == K_DVI) || (kind == K_MDI);

	always_comb begin
		nxt       = '0;
		nxt.kind  = kind;
		nxt.b     = b_value;
		nxt.ex    = ex_in;
		nxt.res   = res;
		nxt.prod  = prod_full[2*WordW-1:0];
		nxt.neg_q = sgn_div && (b_value[WordW-1] ^ a_value[WordW-1]);
		nxt.neg_r = sgn_div && b_value[WordW-1];
		nxt.dzero = (a_value == '0);
		nxt.x     = {(sgn_div && b_value[WordW-1]) ? (~b_value + 1'b1) : b_value,
			{WordW{1'b0}}};
		nxt.d     = (sgn_div && a_value[WordW-1]) ? (~a_value + 1'b1) : a_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== sv/dcpu_div_stage.sv =====
// ----------------------------------------------------------------------------
// dcpu_div_stage
// One divider stage: two restoring quotient steps on a 32-by-16 division.
// ----------------------------------------------------------------------------
module dcpu_div_stage import dcpu_pkg::*; #(
	parameter bit CAPTURE_REM = 1'b0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	output pipe_t out_data,
	input  logic  out_ready
);

	logic  valid_s1;
	pipe_t data_s1;
	pipe_t nxt;
	logic [WordW:0] t;

	assign in_ready = !valid_s1 || out_ready;

	// Two shift, compare and subtract steps.
	always_comb begin
		nxt = in_data;
		t   = '0;
		for (int j = 0; j < 2; j++) begin
			t     = {nxt.r, nxt.x[2*WordW-1]};
			nxt.x = {nxt.x[2*WordW-2:0], 1'b0};
			if (t >= {1'b0, nxt.d}) begin
				nxt.r    = WordW'(t - {1'b0, nxt.d});
				nxt.x[0] = 1'b1;
			end else begin
				nxt.r = t[WordW-1:0];
			end
		end
		// After sixteen steps the partial remainder is b mod a.
		if (CAPTURE_REM) begin
			nxt.rem = nxt.r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== sv/dcpu_back.sv =====
// ----------------------------------------------------------------------------
// dcpu_back
// Last stage: sign fix of quotient and remainder, final result selection.
// ----------------------------------------------------------------------------
module dcpu_back import dcpu_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pipe_t in_data,
	output logic  out_valid,
	output res_t  out_data,
	input  logic  out_ready
);

	logic             valid_q;
	res_t             res_q;
	res_t             nxt;
	logic [WordW-1:0] qh;
	logic [WordW-1:0] ql;
	logic [WordW-1:0] rm;

	assign in_ready = !valid_q || out_ready;

	assign qh = in_data.neg_q ? (~in_data.x[2*WordW-1:WordW] + 1'b1)
		: in_data.x[2*WordW-1:WordW];
	assign ql = in_data.neg_q ? (~in_data.x[WordW-1:0] + 1'b1) : in_data.x[WordW-1:0];
	assign rm = in_data.neg_r ? (~in_data.rem + 1'b1) : in_data.rem;

	// Product, quotient and remainder kinds override the front-end result.
	always_comb begin
		nxt = in_data.res;
		unique case (in_data.kind)
			K_MUL, K_MLI: begin
				nxt.b_result  = in_data.prod[WordW-1:0];
				nxt.ex_result = in_data.prod[2*WordW-1:WordW];
			end
			K_DIV, K_DVI: begin
				nxt.b_result  = in_data.dzero ? '0 : qh;
				nxt.ex_result = in_data.dzero ? '0 : ql;
			end
			K_MOD, K_MDI: nxt.b_result = in_data.dzero ? '0 : rm;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = res_q;

endmodule

// ===== sv/dcpu16_basic_alu.sv =====
// ----------------------------------------------------------------------------
// dcpu16_basic_alu
// DCPU-16 basic instruction ALU with a pipelined 32-by-16 divider.
// ----------------------------------------------------------------------------
// Every request passes one front stage holding the multiplier and the
// single-stage operations, sixteen divider stages of two quotient bits
// each, and one output register. All kinds go through the full depth, so
// results leave in request order, and a new request is taken in every
// cycle while the output side keeps up. Each stage holds its item when the
// next one is full, so bubbles fill in during a stall.
module dcpu16_basic_alu import dcpu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind[4:0], b_value[20:5], a_value[36:21], ex_in[52:37], zero fill
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// b_result[15:0], b_write[16], ex_result[32:17], ex_write[33],
	// skip_next[34], index_step[36:35], zero fill
	output logic [39:0] m_tdata
);

	logic  v [DivStages+1];
	logic  r [DivStages+1];
	pipe_t d [DivStages+1];
	logic  back_ready;
	logic  back_valid;
	res_t  back_data;

	dcpu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.kind      (s_tdata[4:0]),
		.b_value   (s_tdata[20:5]),
		.a_value   (s_tdata[36:21]),
		.ex_in     (s_tdata[52:37]),
		.out_valid (v[0]),
		.out_data  (d[0]),
		.out_ready (r[0])
	);

	// Divider stages in a chain.
	for (genvar i = 0; i < DivStages; i++) begin : g_div
		dcpu_div_stage #(
			.CAPTURE_REM (i == DivRemStage)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (v[i]),
			.in_ready  (r[i]),
			.in_data   (d[i]),
			.out_valid (v[i+1]),
			.out_data  (d[i+1]),
			.out_ready (r[i+1])
		);
	end

	assign r[DivStages] = back_ready;

	dcpu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v[DivStages]),
		.in_ready  (back_ready),
		.in_data   (d[DivStages]),
		.out_valid (back_valid),
		.out_data  (back_data),
		.out_ready (m_tready)
	);

	assign m_tvalid = back_valid;
	assign m_tdata  = {3'b000, back_data.index_step, back_data.skip_next,
		back_data.ex_write, back_data.ex_result, back_data.b_write, back_data.b_result};

`ifndef SYNTH
	// A ready output side drains the whole chain, so the input is ready too.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input not ready while output side is ready");

	// EX is never written by an operation that leaves b untouched.
	a_ex_needs_b: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tdata[16])
		else $error("EX write without b write");

	// A skip only comes from a conditional test, which never writes b.
	a_skip_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34] |-> !m_tdata[16] && !m_tdata[33])
		else $error("skip together with a register write");
`endif

endmodule
